/* design/iap_pkg.sv */
package iap_pkg;

    // digit width of the partial product multipliers
    localparam int LIMB = 32;

    // register stages through one multiplier
    localparam int MUL_LAT = 5;

endpackage

/* design/iap_dly.sv */
module iap_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

/* design/iap_mul.sv */
module iap_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [WA-1:0] a,
    input  logic signed [WB-1:0] b,
    output logic signed [WA+WB-1:0] p
);

    import iap_pkg::*;

    localparam int NA  = (WA + LIMB - 1) / LIMB;
    localparam int NB  = (WB + LIMB - 1) / LIMB;
    localparam int PA  = NA * LIMB;
    localparam int PB  = NB * LIMB;
    localparam int RWD = PB + LIMB;
    localparam int TW  = PA + PB;
    localparam int OW  = WA + WB;

    logic [WA-1:0]       ma_next;
    logic [WB-1:0]       mb_next;
    logic [PA-1:0]       ma_reg;
    logic [PB-1:0]       mb_reg;
    logic [3:0]          sg_reg;
    logic [2*LIMB-1:0]   pp_reg [NA*NB];
    logic [RWD-1:0]      row_next [NA];
    logic [RWD-1:0]      row_reg [NA];
    logic [TW-1:0]       tot_next;
    logic [TW-1:0]       tot_reg;
    logic signed [OW-1:0] p_reg;

    // magnitudes, partial product rows, then the full sum
    always_comb
    begin
        ma_next = a[WA-1] ? $unsigned(-a) : $unsigned(a);
        mb_next = b[WB-1] ? $unsigned(-b) : $unsigned(b);
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (RWD'(pp_reg[i*NB+j]) << (LIMB*j));
            end
        end
        tot_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            tot_next = tot_next + (TW'(row_reg[i]) << (LIMB*i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg    <= PA'(ma_next);
            mb_reg    <= PB'(mb_next);
            sg_reg[0] <= a[WA-1] ^ b[WB-1];
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i*NB+j] <= ma_reg[i*LIMB +: LIMB] * mb_reg[j*LIMB +: LIMB];
                end
            end
            sg_reg[1] <= sg_reg[0];
            row_reg   <= row_next;
            sg_reg[2] <= sg_reg[1];
            tot_reg   <= tot_next;
            sg_reg[3] <= sg_reg[2];
            p_reg     <= sg_reg[3] ? -$signed(tot_reg[OW-1:0]) : $signed(tot_reg[OW-1:0]);
        end
    end

    assign p = p_reg;

endmodule

/* design/iap_sqrt.sv */
module iap_sqrt #(
    parameter int RW = 66
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] n,
    output logic [RW-1:0]   root
);

    localparam int NWD = 2 * RW;

    logic [NWD-1:0] rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    logic [NWD-1:0] rin      [RW];
    logic [NWD-1:0] trial    [RW];
    logic [RW-1:0]  qin      [RW];

    // one root bit per stage, most significant first
    always_comb
    begin
        rin[0] = n;
        qin[0] = '0;
        for (int s = 1; s < RW; s++)
        begin
            rin[s] = rem_reg[s-1];
            qin[s] = root_reg[s-1];
        end
        for (int s = 0; s < RW; s++)
        begin
            trial[s] = (NWD'(qin[s]) << (RW - s)) | (NWD'(1) << (2 * (RW - 1 - s)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < RW; s++)
            begin
                if (rin[s] >= trial[s])
                begin
                    rem_reg[s]  <= rin[s] - trial[s];
                    root_reg[s] <= qin[s] | (RW'(1) << (RW - 1 - s));
                end
                else
                begin
                    rem_reg[s]  <= rin[s];
                    root_reg[s] <= qin[s];
                end
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

/* design/iap_div.sv */
module iap_div #(
    parameter int NWD = 100,
    parameter int DWD = 65,
    parameter int QB  = 34
) (
    input  logic           clk,
    input  logic           en,
    input  logic [NWD-1:0] num,
    input  logic [DWD-1:0] den,
    output logic [QB-1:0]  quo
);

    logic [NWD-1:0] rem_reg [QB];
    logic [DWD-1:0] den_reg [QB];
    logic [QB-1:0]  quo_reg [QB];
    logic [NWD-1:0] rin     [QB];
    logic [DWD-1:0] din     [QB];
    logic [QB-1:0]  qin     [QB];
    logic [NWD-1:0] test    [QB];

    // restoring division, one quotient bit per stage
    always_comb
    begin
        rin[0] = num;
        din[0] = den;
        qin[0] = '0;
        for (int s = 1; s < QB; s++)
        begin
            rin[s] = rem_reg[s-1];
            din[s] = den_reg[s-1];
            qin[s] = quo_reg[s-1];
        end
        for (int s = 0; s < QB; s++)
        begin
            test[s] = NWD'(din[s]) << (QB - 1 - s);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < QB; s++)
            begin
                den_reg[s] <= din[s];
                if (rin[s] >= test[s])
                begin
                    rem_reg[s] <= rin[s] - test[s];
                    quo_reg[s] <= qin[s] | (QB'(1) << (QB - 1 - s));
                end
                else
                begin
                    rem_reg[s] <= rin[s];
                    quo_reg[s] <= qin[s];
                end
            end
        end
    end

    assign quo = quo_reg[QB-1];

endmodule

/* design/intercept_aim_point.sv */
// throughput: one transaction per cycle while the output buffer is not full;
// square root and divider resolve one bit per stage
// three five-stage multiplier rounds, a 2-entry output buffer absorbs output stalls
// reset: rst_n asynchronous active low, clears the valid bits and the output buffer;
// datapath registers are not reset
module intercept_aim_point #(
    parameter int COORD_WIDTH = 32,
    localparam int IN_W  = ((10 * COORD_WIDTH - 1 + 7) / 8) * 8,
    localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // target_x, target_y, target_z, vel_x, vel_y, vel_z, origin_x, origin_y, origin_z,
    // shot_speed
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // aim_x, aim_y, aim_z
    output logic [OUT_W-1:0] m_axis_tdata,
    // found
    output logic [0:0]       m_axis_tuser
);

    import iap_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int HW  = 2 * W + 3;
    localparam int AW  = 2 * W + 1;
    localparam int QW  = 2 * HW;
    localparam int RW  = 2 * W + 2;
    localparam int NW  = 2 * W + 4;
    localparam int PW  = W + NW;
    localparam int QB  = W + 2;
    localparam int SW  = W + 4;
    localparam int NST = 5 + 3 * MUL_LAT + RW + QB;
    localparam int EW  = 3 * W + 1;
    localparam logic [1:0] BUF_FULL = 2'd2;

    logic              en;
    logic [NST-1:0]    vld_reg;

    // input stage
    logic signed [W-1:0]  t_in [3];
    logic signed [W-1:0]  v_in [3];
    logic signed [W-1:0]  o_in [3];
    logic signed [W-1:0]  t_reg [3];
    logic signed [W-1:0]  v_reg [3];
    logic signed [DW-1:0] d_reg [3];
    logic [W-2:0]         s_reg;

    // dot products
    logic signed [DW+W-1:0] dv [3];
    logic signed [2*DW-1:0] dd [3];
    logic signed [2*W-1:0]  vv [3];
    logic signed [2*W-1:0]  ss;
    logic signed [HW-1:0]   h_reg;
    logic signed [HW-1:0]   c_reg;
    logic signed [AW-1:0]   a_reg;

    // discriminant and root
    logic signed [QW-1:0]    hh;
    logic signed [AW+HW-1:0] ac;
    logic signed [QW-1:0]    disc;
    logic [2*RW-1:0]         sq_reg;
    logic                    neg_reg;
    logic [RW-1:0]           root;
    logic                    neg_p6;
    logic signed [HW-1:0]    h_p6;
    logic signed [AW-1:0]    a_p6;

    // root choice
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
    logic                 pos1;
    logic                 pos2;
    logic signed [NW-1:0] num_reg;
    logic                 found_reg;
    logic                 aneg_reg;
    logic [AW-1:0]        absa_reg;
    logic [3*W-1:0]       v_p7;
    logic signed [W-1:0]  v_p7a [3];

    // products and quotient
    logic signed [PW-1:0] p [3];
    logic [AW+1:0]        side_p8;
    logic [PW-1:0]        magp [3];
    logic [PW-1:0]        magp_reg [3];
    logic                 negq_reg [3];
    logic                 ovf_reg [3];
    logic [AW-1:0]        absa8_reg;
    logic                 found8_reg;
    logic [QB-1:0]        quo [3];
    logic [6:0]           side_p10;
    logic [3*W-1:0]       t_p10;

    // final sum
    logic [QB-1:0]         qmag;
    logic signed [SW-1:0]  qs;
    logic signed [SW-1:0]  sum;
    logic [W-1:0]          aim [3];
    logic [EW-1:0]         entry;

    // output buffer
    logic [EW-1:0] buf_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          push;
    logic          pop;

    assign en            = cnt_reg != BUF_FULL;
    assign s_axis_tready = en;
    assign push          = en && vld_reg[NST-1];
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
        end
    end

    // input unpack and offset
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_in[i] = $signed(s_axis_tdata[i*W +: W]);
            v_in[i] = $signed(s_axis_tdata[(3+i)*W +: W]);
            o_in[i] = $signed(s_axis_tdata[(6+i)*W +: W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t_reg[i] <= t_in[i];
                v_reg[i] <= v_in[i];
                d_reg[i] <= DW'(t_in[i]) - DW'(o_in[i]);
            end
            s_reg <= s_axis_tdata[9*W +: W-1];
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        iap_mul #(.WA(DW), .WB(W)) u_dv (
            .clk(clk), .en(en), .a(d_reg[i]), .b(v_reg[i]), .p(dv[i])
        );
        iap_mul #(.WA(DW), .WB(DW)) u_dd (
            .clk(clk), .en(en), .a(d_reg[i]), .b(d_reg[i]), .p(dd[i])
        );
        iap_mul #(.WA(W), .WB(W)) u_vv (
            .clk(clk), .en(en), .a(v_reg[i]), .b(v_reg[i]), .p(vv[i])
        );
    end

    iap_mul #(.WA(W), .WB(W)) u_ss (
        .clk(clk), .en(en), .a($signed({1'b0, s_reg})), .b($signed({1'b0, s_reg})), .p(ss)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg <= HW'(dv[0]) + HW'(dv[1]) + HW'(dv[2]);
            c_reg <= HW'(dd[0]) + HW'(dd[1]) + HW'(dd[2]);
            a_reg <= AW'(vv[0]) + AW'(vv[1]) + AW'(vv[2]) - AW'(ss);
        end
    end

    iap_mul #(.WA(HW), .WB(HW)) u_hh (
        .clk(clk), .en(en), .a(h_reg), .b(h_reg), .p(hh)
    );

    iap_mul #(.WA(AW), .WB(HW)) u_ac (
        .clk(clk), .en(en), .a(a_reg), .b(c_reg), .p(ac)
    );

    assign disc = hh - QW'(ac);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= disc[QW-1];
            sq_reg  <= disc[QW-1] ? '0 : disc[2*RW-1:0];
        end
    end

    iap_sqrt #(.RW(RW)) u_sqrt (
        .clk(clk), .en(en), .n(sq_reg), .root(root)
    );

    iap_dly #(.WIDTH(1), .DEPTH(RW)) u_neg_dly (
        .clk(clk), .en(en), .din(neg_reg), .dout(neg_p6)
    );

    iap_dly #(.WIDTH(HW), .DEPTH(MUL_LAT + 1 + RW)) u_h_dly (
        .clk(clk), .en(en), .din(h_reg), .dout(h_p6)
    );

    iap_dly #(.WIDTH(AW), .DEPTH(MUL_LAT + 1 + RW)) u_a_dly (
        .clk(clk), .en(en), .din(a_reg), .dout(a_p6)
    );

    // plus-sign root first, then minus-sign root
    always_comb
    begin
        n1   = $signed(NW'(root)) - NW'(h_p6);
        n2   = -$signed(NW'(root)) - NW'(h_p6);
        pos1 = (n1 != '0) && (n1[NW-1] == a_p6[AW-1]);
        pos2 = (n2 != '0) && (n2[NW-1] == a_p6[AW-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            found_reg <= !neg_p6 && (a_p6 != '0) && (pos1 || pos2);
            num_reg   <= pos1 ? n1 : n2;
            aneg_reg  <= a_p6[AW-1];
            absa_reg  <= a_p6[AW-1] ? $unsigned(-a_p6) : $unsigned(a_p6);
        end
    end

    iap_dly #(.WIDTH(3*W), .DEPTH(3 + 2*MUL_LAT + RW)) u_v_dly (
        .clk(clk), .en(en), .din({v_reg[2], v_reg[1], v_reg[0]}), .dout(v_p7)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_lead
        assign v_p7a[i] = $signed(v_p7[i*W +: W]);

        iap_mul #(.WA(W), .WB(NW)) u_vn (
            .clk(clk), .en(en), .a(v_p7a[i]), .b(num_reg), .p(p[i])
        );

        assign magp[i] = p[i][PW-1] ? $unsigned(-p[i]) : $unsigned(p[i]);

        iap_div #(.NWD(PW), .DWD(AW), .QB(QB)) u_div (
            .clk(clk), .en(en), .num(magp_reg[i]), .den(absa8_reg), .quo(quo[i])
        );
    end

    iap_dly #(.WIDTH(AW+2), .DEPTH(MUL_LAT)) u_side_dly (
        .clk(clk), .en(en), .din({found_reg, aneg_reg, absa_reg}), .dout(side_p8)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                magp_reg[i] <= magp[i];
                negq_reg[i] <= p[i][PW-1] ^ side_p8[AW];
                ovf_reg[i]  <= (magp[i] >> QB) >= PW'(side_p8[AW-1:0]);
            end
            absa8_reg  <= side_p8[AW-1:0];
            found8_reg <= side_p8[AW+1];
        end
    end

    iap_dly #(.WIDTH(7), .DEPTH(QB)) u_flag_dly (
        .clk(clk), .en(en),
        .din({found8_reg, ovf_reg[2], ovf_reg[1], ovf_reg[0],
              negq_reg[2], negq_reg[1], negq_reg[0]}),
        .dout(side_p10)
    );

    iap_dly #(.WIDTH(3*W), .DEPTH(NST - 1)) u_t_dly (
        .clk(clk), .en(en), .din({t_reg[2], t_reg[1], t_reg[0]}), .dout(t_p10)
    );

    // signed quotient added to the target, saturated; the target alone when no intercept is found
    always_comb
    begin
        qmag = '0;
        qs   = '0;
        sum  = '0;
        for (int i = 0; i < 3; i++)
        begin
            qmag = side_p10[3+i] ? '1 : quo[i];
            qs   = side_p10[i] ? -$signed(SW'(qmag)) : $signed(SW'(qmag));
            sum  = SW'($signed(t_p10[i*W +: W])) + qs;
            if (!side_p10[6])
            begin
                aim[i] = t_p10[i*W +: W];
            end
            else if (sum[SW-1:W-1] != {(SW-W+1){sum[SW-1]}})
            begin
                aim[i] = sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                aim[i] = sum[W-1:0];
            end
        end
        entry = {side_p10[6], aim[2], aim[1], aim[0]};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign m_axis_tvalid = cnt_reg != '0;
    assign m_axis_tdata  = OUT_W'(buf_reg[rd_ptr_reg][3*W-1:0]);
    assign m_axis_tuser  = buf_reg[rd_ptr_reg][3*W];

endmodule

/* design/iap_chk.sv */
module iap_chk #(
    parameter int COORD_WIDTH = 32,
    localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [0:0]       m_axis_tuser
);

    // stalled result transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // stalled result does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // empty output side never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with nothing to deliver");

    // blocked input stays blocked until a result leaves
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready && !s_axis_tready |=> !s_axis_tready)
        else $error("input released without a result leaving");

endmodule

bind intercept_aim_point iap_chk #(.COORD_WIDTH(COORD_WIDTH)) u_iap_chk (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);

/* test/tb_intercept_aim_point.sv */
module tb_intercept_aim_point;

    localparam int CW    = 32;
    localparam int IN_W  = ((10 * CW - 1 + 7) / 8) * 8;
    localparam int OUT_W = ((3 * CW + 7) / 8) * 8;
    localparam int BW    = 260;
    localparam int N_RANDOM = 1450;
    localparam int SETTLE = 3 * CW + 60;

    typedef logic signed [BW-1:0] wide_t;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic                 found;
    } aim_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    logic [IN_W-1:0] pending_q[$];
    aim_t aim_expected_q[$];
    int mismatches;
    int results_seen;
    int found_seen;
    bit stim_done;
    int send_gap;
    int recv_gap;
    int hold_cycles;
    int out_count;
    bit hold_done;

    intercept_aim_point #(.COORD_WIDTH(CW)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic wide_t isqrt_floor(wide_t n);
        wide_t res;
        wide_t bitv;
        wide_t rb;
        res = '0;
        bitv = wide_t'(1) <<< (BW - 4);
        while (bitv != 0 && bitv > n)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            rb = res + bitv;
            if (n >= rb)
            begin
                n = n - rb;
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(wide_t x);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (CW - 1)) - 1;
        lo = -(wide_t'(1) <<< (CW - 1));
        if (x > hi)
            return hi[CW-1:0];
        if (x < lo)
            return lo[CW-1:0];
        return x[CW-1:0];
    endfunction

    function automatic aim_t solve_intercept(logic [IN_W-1:0] item);
        wide_t tg[3];
        wide_t vl[3];
        wide_t dv[3];
        wide_t h;
        wide_t c;
        wide_t a;
        wide_t q;
        wide_t r;
        wide_t n1;
        wide_t n2;
        wide_t num;
        wide_t p;
        wide_t quo;
        wide_t spd;
        aim_t res;
        logic [CW-1:0] coord[3];
        h = 0;
        c = 0;
        num = 0;
        res.found = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            tg[i] = wide_t'($signed(item[i*CW +: CW]));
            vl[i] = wide_t'($signed(item[(3+i)*CW +: CW]));
            dv[i] = tg[i] - wide_t'($signed(item[(6+i)*CW +: CW]));
        end
        spd = wide_t'({1'b0, item[9*CW +: CW-1]});
        a = -(spd * spd);
        for (int i = 0; i < 3; i++)
        begin
            h = h + dv[i] * vl[i];
            c = c + dv[i] * dv[i];
            a = a + vl[i] * vl[i];
        end
        if (a != 0)
        begin
            q = h * h - a * c;
            if (q >= 0)
            begin
                r = isqrt_floor(q);
                n1 = -h + r;
                n2 = -h - r;
                if (n1 != 0 && (n1 < 0) == (a < 0))
                begin
                    num = n1;
                    res.found = 1'b1;
                end
                else if (n2 != 0 && (n2 < 0) == (a < 0))
                begin
                    num = n2;
                    res.found = 1'b1;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (res.found)
            begin
                p = vl[i] * num;
                quo = p / a;
                coord[i] = clamp_coord(tg[i] + quo);
            end
            else
                coord[i] = tg[i][CW-1:0];
        end
        res.ax = coord[0];
        res.ay = coord[1];
        res.az = coord[2];
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_item(logic [CW-1:0] f[9], logic [CW-2:0] spd);
        logic [IN_W-1:0] item;
        item = '0;
        for (int i = 0; i < 9; i++)
            item[i*CW +: CW] = f[i];
        item[9*CW +: CW-1] = spd;
        return item;
    endfunction

    function automatic logic [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return CW'($signed($urandom_range(0, 4000000)) - 2000000);
            2: return CW'($signed($urandom_range(0, 200000000)) - 100000000);
            default: return {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom())};
        endcase
    endfunction

    task automatic queue_item(logic [CW-1:0] f[9], logic [CW-2:0] spd);
        pending_q.push_back(pack_item(f, spd));
    endtask

    initial
    begin
        logic [CW-1:0] f[9];
        logic [CW-2:0] spd;
        logic [CW-1:0] extremes[4];
        int mode;
        extremes[0] = 32'h8000_0000;
        extremes[1] = 32'h7fff_ffff;
        extremes[2] = 32'h0000_0000;
        extremes[3] = 32'hffff_ffff;
        // all-equal extremes, zero and maximum speed
        for (int e = 0; e < 4; e++)
        begin
            for (int i = 0; i < 9; i++)
                f[i] = extremes[e];
            queue_item(f, '0);
            queue_item(f, '1);
        end
        // stationary target, shooter at origin: a < 0, one positive root
        f = '{32'h0010_0000, 0, 0, 0, 0, 0, 0, 0, 0};
        queue_item(f, 31'h0001_0000);
        // target faster than shot moving away: both roots negative, no intercept
        f = '{32'h0010_0000, 0, 0, 32'h0005_0000, 0, 0, 0, 0, 0};
        queue_item(f, 31'h0001_0000);
        // equal speeds: zero quadratic term
        queue_item(f, 31'h0005_0000);
        // faster target approaching: two positive roots
        f = '{32'h0010_0000, 0, 0, 32'hfffb_0000, 0, 0, 0, 0, 0};
        queue_item(f, 31'h0001_0000);
        // target on top of shooter: t = 0
        f = '{32'h0003_0000, 32'h0002_0000, 0, 32'h0001_0000, 0, 0,
              32'h0003_0000, 32'h0002_0000, 0};
        queue_item(f, 31'h0002_0000);
        // saturation: huge velocity, slow and fast shot
        f = '{32'h7fff_0000, 32'h8000_1000, 32'h4000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
        queue_item(f, 31'h0000_0001);
        queue_item(f, '1);
        f = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        queue_item(f, 31'h4000_0000);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++)
                f[i] = rand_coord($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : mode);
            case ($urandom_range(0, 3))
                0: spd = 31'($urandom());
                1: spd = 31'($urandom_range(0, 8000000));
                2: spd = 31'($urandom_range(0, 400000000));
                default: spd = {1'b0, 30'($urandom())};
            endcase
            queue_item(f, spd);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        results_seen = 0;
        found_seen = 0;
        stim_done = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        hold_cycles = 0;
        out_count = 0;
        hold_done = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                aim_expected_q.push_back(solve_intercept(s_axis_tdata));
                send_gap = pick_gap();
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0 || pending_q.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    s_axis_tvalid <= 1'b0;
                    if (pending_q.size() == 0)
                        stim_done = 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_q.pop_front();
                end
            end
        end
    end

    // one long hold-off of the receiver while the sender keeps going
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                out_count <= out_count + 1;
            if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
            else if (out_count == 40 && !hold_done)
            begin
                hold_cycles <= 400;
                hold_done <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        aim_t want;
        aim_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.ax = m_axis_tdata[0 +: CW];
                got.ay = m_axis_tdata[CW +: CW];
                got.az = m_axis_tdata[2*CW +: CW];
                got.found = m_axis_tuser[0];
                results_seen++;
                if (got.found)
                    found_seen++;
                if (aim_expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %h found %b", m_axis_tdata, got.found);
                end
                else
                begin
                    want = aim_expected_q.pop_front();
                    if (want != got)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h %h %h found %b, got %h %h %h found %b",
                                want.ax, want.ay, want.az, want.found,
                                got.ax, got.ay, got.az, got.found);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                recv_gap = pick_gap();
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        wait (rst_n && stim_done);
        while (aim_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("%0d solutions checked, %0d with an intercept found, %0d without",
            results_seen, found_seen, results_seen - found_seen);
        if (mismatches == 0 && aim_expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule
